// File: hw/rtl/alpe_pkg.sv
// Shared types and constants for the addressable LED pulse encoder.
`default_nettype none
package alpe_pkg;

	localparam int unsigned COLOR_W   = 8;
	localparam int unsigned WORD_W    = 3 * COLOR_W;
	localparam int unsigned BIT_CNT_W = 5;
	localparam int unsigned SHORT_W   = 12;
	localparam int unsigned LONG_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	// Register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW = 3'd4;

	// Reset values
	localparam logic [SHORT_W-1:0] RST_ONE_HIGH  = 12'd13;
	localparam logic [SHORT_W-1:0] RST_ONE_LOW   = 12'd7;
	localparam logic [SHORT_W-1:0] RST_ZERO_HIGH = 12'd6;
	localparam logic [SHORT_W-1:0] RST_ZERO_LOW  = 12'd14;
	localparam logic [LONG_W-1:0]  RST_RESET_LOW = 16'd800;

	// Index of the last bit of an LED word, counted down to zero
	localparam logic [BIT_CNT_W-1:0] LAST_BIT_IDX = 5'(WORD_W - 1);

	// Timing registers, zero already replaced by one
	typedef struct packed {
		logic [SHORT_W-1:0] one_high;
		logic [SHORT_W-1:0] one_low;
		logic [SHORT_W-1:0] zero_high;
		logic [SHORT_W-1:0] zero_low;
		logic [LONG_W-1:0]  reset_low;
	} timing_cfg_t;

	// One LED as queued between front and back: GRB word, MSB first
	typedef struct packed {
		logic [WORD_W-1:0] bits;
		logic              final_led;
	} led_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/alpe_if.sv
// Valid/ready channel interfaces for LED items and line segments.
`default_nettype none
interface alpe_pixel_if;
	import alpe_pkg::*;
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] green_level;
	logic [COLOR_W-1:0] red_level;
	logic [COLOR_W-1:0] blue_level;
	logic               final_led;

	modport source (output valid, green_level, red_level, blue_level, final_led,
		input ready);
	modport sink (input valid, green_level, red_level, blue_level, final_led,
		output ready);
endinterface

interface alpe_segment_if;
	import alpe_pkg::*;
	logic              valid;
	logic              ready;
	logic              line_level;
	logic [LONG_W-1:0] segment_cycles;
	logic              run_end;

	modport source (output valid, line_level, segment_cycles, run_end, input ready);
	modport sink (input valid, line_level, segment_cycles, run_end, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/alpe_cfg_regs.sv
// Timing configuration registers with zero-to-one clamping on write.
`default_nettype none
module alpe_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire [alpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [alpe_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	output alpe_pkg::timing_cfg_t          timing
);
	import alpe_pkg::*;

	timing_cfg_t        timing_q;
	logic [SHORT_W-1:0] short_val;
	logic [LONG_W-1:0]  long_val;

	// a zero duration is stored as one
	always_comb begin
		short_val = (cfg_wdata[SHORT_W-1:0] == '0) ? SHORT_W'(1) : cfg_wdata[SHORT_W-1:0];
		long_val  = (cfg_wdata[LONG_W-1:0] == '0) ? LONG_W'(1) : cfg_wdata[LONG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.one_high  <= RST_ONE_HIGH;
			timing_q.one_low   <= RST_ONE_LOW;
			timing_q.zero_high <= RST_ZERO_HIGH;
			timing_q.zero_low  <= RST_ZERO_LOW;
			timing_q.reset_low <= RST_RESET_LOW;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ONE_HIGH:  timing_q.one_high  <= short_val;
				CFG_ONE_LOW:   timing_q.one_low   <= short_val;
				CFG_ZERO_HIGH: timing_q.zero_high <= short_val;
				CFG_ZERO_LOW:  timing_q.zero_low  <= short_val;
				CFG_RESET_LOW: timing_q.reset_low <= long_val;
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule
`default_nettype wire

// File: hw/rtl/alpe_front.sv
// Front end: accepts LED items, packs the GRB word and queues it.
`default_nettype none
module alpe_front #(
	parameter int unsigned DEPTH = 2
) (
	input  wire                     clk,
	input  wire                     arst_n,
	alpe_pixel_if.sink              pixel,
	input  wire                     pop,
	output logic                    q_valid,
	output alpe_pkg::led_word_t     q_data
);
	import alpe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	led_word_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               do_pop;
	led_word_t          packed_word;

	assign pixel.ready = (count_q != CNT_W'(DEPTH));
	assign push        = pixel.valid && pixel.ready;
	assign q_valid     = (count_q != '0);
	assign do_pop      = pop && q_valid;
	assign q_data      = mem_q[rd_ptr_q];

	always_comb begin
		packed_word.bits      = {pixel.green_level, pixel.red_level, pixel.blue_level};
		packed_word.final_led = pixel.final_led;
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= packed_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/alpe_seg_gen.sv
// Back end: walks one queued LED word and emits its line segments.
`default_nettype none
module alpe_seg_gen (
	input  wire                     clk,
	input  wire                     arst_n,
	input  alpe_pkg::timing_cfg_t   timing,
	input  wire                     q_valid,
	input  alpe_pkg::led_word_t     q_data,
	output logic                    pop,
	alpe_segment_if.source          segment
);
	import alpe_pkg::*;

	logic                 busy_q;
	logic [WORD_W-1:0]    word_q;
	logic                 final_q;
	logic [BIT_CNT_W-1:0] bit_idx_q;
	logic                 low_phase_q;
	logic                 tail_q;

	logic                 out_valid_q;
	logic                 out_level_q;
	logic [LONG_W-1:0]    out_cycles_q;
	logic                 out_end_q;

	logic                 advance;
	logic                 cur_bit;
	logic                 nxt_level;
	logic [LONG_W-1:0]    nxt_cycles;
	logic                 nxt_end;
	logic                 item_done;

	assign pop     = !busy_q && q_valid;
	assign advance = busy_q && (!out_valid_q || segment.ready);
	assign cur_bit = word_q[WORD_W-1];

	always_comb begin
		nxt_level  = 1'b0;
		nxt_cycles = timing.reset_low;
		nxt_end    = 1'b1;
		item_done  = 1'b1;
		if (!tail_q) begin
			if (!low_phase_q) begin
				nxt_level  = 1'b1;
				nxt_cycles = LONG_W'(cur_bit ? timing.one_high : timing.zero_high);
				nxt_end    = 1'b0;
				item_done  = 1'b0;
			end else begin
				nxt_cycles = LONG_W'(cur_bit ? timing.one_low : timing.zero_low);
				nxt_end    = (bit_idx_q == '0) && !final_q;
				item_done  = nxt_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q  <= q_data.bits;
			final_q <= q_data.final_led;
		end else if (advance && low_phase_q && !tail_q) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
		end
		if (advance) begin
			out_level_q  <= nxt_level;
			out_cycles_q <= nxt_cycles;
			out_end_q    <= nxt_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			bit_idx_q   <= '0;
			low_phase_q <= 1'b0;
			tail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q      <= 1'b1;
				bit_idx_q   <= LAST_BIT_IDX;
				low_phase_q <= 1'b0;
				tail_q      <= 1'b0;
			end else if (advance) begin
				if (item_done) begin
					busy_q <= 1'b0;
				end else if (!low_phase_q) begin
					low_phase_q <= 1'b1;
				end else begin
					low_phase_q <= 1'b0;
					if (bit_idx_q == '0)
						tail_q <= 1'b1;
					else
						bit_idx_q <= bit_idx_q - BIT_CNT_W'(1);
				end
			end

			if (advance)
				out_valid_q <= 1'b1;
			else if (segment.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign segment.valid          = out_valid_q;
	assign segment.line_level     = out_level_q;
	assign segment.segment_cycles = out_cycles_q;
	assign segment.run_end        = out_end_q;

endmodule
`default_nettype wire

// File: hw/rtl/addressable_led_pulse_encoder_unit.sv
// Top level of the addressable LED pulse encoder.
`default_nettype none
// Turns one LED color per item (green, red, blue bytes plus a last-LED
// flag) into the segment list for a single-wire LED strip: 24 bits sent
// green, red, blue, MSB first, each bit as a high segment then a low
// segment whose lengths come from the one/zero timing registers, and for
// the strip's last LED a trailing low latch segment of reset_low cycles.
// An item yields 48 segments, 49 with final_led set; run_end marks the
// last one. A register written with 0 acts as 1. Timing: the back end
// emits one segment per clock while the segment sink is ready and no
// item is being loaded from the queue; the segment output port sets the
// pace. An item is queued, then loaded, before its first segment is
// registered. The front queue holds QUEUE_DEPTH items, so the next LEDs
// are taken while the current one is still being sent. Config writes
// must happen only while idle.
module addressable_led_pulse_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire [alpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [alpe_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	alpe_pixel_if.sink                     pixel,
	alpe_segment_if.source                 segment
);
	import alpe_pkg::*;

	timing_cfg_t timing;
	logic        q_valid;
	led_word_t   q_data;
	logic        pop;

	// timing registers, a written zero clamped to one
	alpe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.timing    (timing)
	);

	// front: accept and pack items into the queue
	alpe_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.pop     (pop),
		.q_valid (q_valid),
		.q_data  (q_data)
	);

	// back: bit walker with a registered segment output
	alpe_seg_gen u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.timing  (timing),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.segment (segment)
	);

endmodule
`default_nettype wire
